// ===== design/triangle_barycentric_point_test_assert.svh =====
// ----------------------------------------------------------------------------
// Barycentric point test assertion macros
// Shared assertion forms for the point test modules, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_POINT_TEST_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_POINT_TEST_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define TBPT_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("point test assertion failed");

// The property must hold in the cycle after the condition.
`define TBPT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("point test assertion failed");

`endif

// ===== design/tbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Barycentric point test package
// Widths, constants and types shared by the point test pipeline.
// ----------------------------------------------------------------------------
package tbpt_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 24;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * COORD_BITS + 2;
  localparam int DOT_W   = 2 * COORD_BITS + 3;
  localparam int SPLIT   = (DOT_W + 1) / 2;
  localparam int HI_W    = DOT_W - SPLIT;
  localparam int PH_W    = DOT_W + HI_W;
  localparam int PL_W    = DOT_W + SPLIT + 1;
  localparam int NUM_W   = 4 * COORD_BITS + 8;
  localparam int LO_BITS = WEIGHT_BITS - FRAC_BITS;
  localparam int NUM_COORDS = 12;
  localparam int NUM_PRODS  = 6;

  localparam logic [WEIGHT_BITS-1:0] W_POS_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] W_NEG_MAG = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [DOT_W-1:0] d1;
    logic signed [DOT_W-1:0] d2;
    logic signed [DOT_W-1:0] s11;
    logic signed [DOT_W-1:0] s12;
    logic signed [DOT_W-1:0] s22;
  } dots_t;

  typedef struct packed {
    logic                   neg;
    logic                   ovf;
    logic [NUM_W-1:0]       rem;
    logic [WEIGHT_BITS-1:0] lo;
    logic [WEIGHT_BITS-1:0] q;
  } lane_t;

  typedef struct packed {
    logic in_tri;
    logic degen;
  } flags_t;

endpackage

// ===== design/tbpt_front.sv =====
// ----------------------------------------------------------------------------
// Barycentric point test front end
// Edge vectors, point offset and the five dot products in three stages.
// ----------------------------------------------------------------------------
module tbpt_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0] coord [tbpt_pkg::NUM_COORDS],
  output logic                                 out_valid,
  output tbpt_pkg::dots_t                      dots
);

  logic                              v1, v2;
  logic signed [tbpt_pkg::DIFF_W-1:0] e1 [3];
  logic signed [tbpt_pkg::DIFF_W-1:0] e2 [3];
  logic signed [tbpt_pkg::DIFF_W-1:0] dv [3];
  logic signed [tbpt_pkg::PROD_W-1:0] pd1 [3];
  logic signed [tbpt_pkg::PROD_W-1:0] pd2 [3];
  logic signed [tbpt_pkg::PROD_W-1:0] p11 [3];
  logic signed [tbpt_pkg::PROD_W-1:0] p12 [3];
  logic signed [tbpt_pkg::PROD_W-1:0] p22 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= tbpt_pkg::DIFF_W'(coord[3 + k]) - tbpt_pkg::DIFF_W'(coord[k]);
        e2[k] <= tbpt_pkg::DIFF_W'(coord[6 + k]) - tbpt_pkg::DIFF_W'(coord[k]);
        dv[k] <= tbpt_pkg::DIFF_W'(coord[9 + k]) - tbpt_pkg::DIFF_W'(coord[k]);
      end
      for (int k = 0; k < 3; k++) begin
        pd1[k] <= tbpt_pkg::PROD_W'(dv[k]) * tbpt_pkg::PROD_W'(e1[k]);
        pd2[k] <= tbpt_pkg::PROD_W'(dv[k]) * tbpt_pkg::PROD_W'(e2[k]);
        p11[k] <= tbpt_pkg::PROD_W'(e1[k]) * tbpt_pkg::PROD_W'(e1[k]);
        p12[k] <= tbpt_pkg::PROD_W'(e1[k]) * tbpt_pkg::PROD_W'(e2[k]);
        p22[k] <= tbpt_pkg::PROD_W'(e2[k]) * tbpt_pkg::PROD_W'(e2[k]);
      end
      dots.d1  <= tbpt_pkg::DOT_W'(pd1[0]) + tbpt_pkg::DOT_W'(pd1[1])
                + tbpt_pkg::DOT_W'(pd1[2]);
      dots.d2  <= tbpt_pkg::DOT_W'(pd2[0]) + tbpt_pkg::DOT_W'(pd2[1])
                + tbpt_pkg::DOT_W'(pd2[2]);
      dots.s11 <= tbpt_pkg::DOT_W'(p11[0]) + tbpt_pkg::DOT_W'(p11[1])
                + tbpt_pkg::DOT_W'(p11[2]);
      dots.s12 <= tbpt_pkg::DOT_W'(p12[0]) + tbpt_pkg::DOT_W'(p12[1])
                + tbpt_pkg::DOT_W'(p12[2]);
      dots.s22 <= tbpt_pkg::DOT_W'(p22[0]) + tbpt_pkg::DOT_W'(p22[1])
                + tbpt_pkg::DOT_W'(p22[2]);
    end
  end

endmodule

// ===== design/tbpt_gram.sv =====
// ----------------------------------------------------------------------------
// Barycentric point test Gram stage
// Split wide products, Gram determinant, numerators, magnitudes and the
// divider start values, in six stages.
// ----------------------------------------------------------------------------
module tbpt_gram (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  tbpt_pkg::dots_t                dots,
  output logic                           out_valid,
  output tbpt_pkg::lane_t                lanes [3],
  output logic [tbpt_pkg::NUM_W-1:0]     gram_out,
  output tbpt_pkg::flags_t               flags
);

  logic signed [tbpt_pkg::DOT_W-1:0] ma [tbpt_pkg::NUM_PRODS];
  logic signed [tbpt_pkg::DOT_W-1:0] mb [tbpt_pkg::NUM_PRODS];
  logic signed [tbpt_pkg::PH_W-1:0]  ph [tbpt_pkg::NUM_PRODS];
  logic signed [tbpt_pkg::PL_W-1:0]  pl [tbpt_pkg::NUM_PRODS];
  logic signed [tbpt_pkg::NUM_W-1:0] pr [tbpt_pkg::NUM_PRODS];
  logic signed [tbpt_pkg::NUM_W-1:0] g6, nb6, nc6;
  logic signed [tbpt_pkg::NUM_W-1:0] g7, nb7, nc7, na7;
  logic                              degen7, degen8;
  logic [tbpt_pkg::NUM_W-1:0]        g8;
  logic [tbpt_pkg::NUM_W-1:0]        mag8 [3];
  logic [2:0]                        neg8;
  logic [tbpt_pkg::NUM_W-1:0]        top8 [3];
  logic                              v4, v5, v6, v7, v8;

  always_comb begin
    ma[0] = dots.s11; mb[0] = dots.s22;
    ma[1] = dots.s12; mb[1] = dots.s12;
    ma[2] = dots.d1;  mb[2] = dots.s22;
    ma[3] = dots.s12; mb[3] = dots.d2;
    ma[4] = dots.s11; mb[4] = dots.d2;
    ma[5] = dots.d1;  mb[5] = dots.s12;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      top8[k] = mag8[k] >> tbpt_pkg::LO_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < tbpt_pkg::NUM_PRODS; j++) begin
        ph[j] <= tbpt_pkg::PH_W'(ma[j])
               * tbpt_pkg::PH_W'($signed(mb[j][tbpt_pkg::DOT_W-1:tbpt_pkg::SPLIT]));
        pl[j] <= tbpt_pkg::PL_W'(ma[j])
               * tbpt_pkg::PL_W'($signed({1'b0, mb[j][tbpt_pkg::SPLIT-1:0]}));
        pr[j] <= (tbpt_pkg::NUM_W'(ph[j]) <<< tbpt_pkg::SPLIT)
               + tbpt_pkg::NUM_W'(pl[j]);
      end
      g6  <= pr[0] - pr[1];
      nb6 <= pr[2] - pr[3];
      nc6 <= pr[4] - pr[5];

      g7     <= g6;
      nb7    <= nb6;
      nc7    <= nc6;
      na7    <= g6 - nb6 - nc6;
      degen7 <= g6[tbpt_pkg::NUM_W-1] || (g6 == '0);

      g8      <= $unsigned(g7);
      degen8  <= degen7;
      neg8    <= {nc7[tbpt_pkg::NUM_W-1], nb7[tbpt_pkg::NUM_W-1], na7[tbpt_pkg::NUM_W-1]};
      mag8[0] <= na7[tbpt_pkg::NUM_W-1] ? $unsigned(-na7) : $unsigned(na7);
      mag8[1] <= nb7[tbpt_pkg::NUM_W-1] ? $unsigned(-nb7) : $unsigned(nb7);
      mag8[2] <= nc7[tbpt_pkg::NUM_W-1] ? $unsigned(-nc7) : $unsigned(nc7);

      gram_out     <= g8;
      flags.degen  <= degen8;
      flags.in_tri <= !degen8 && (neg8 == 3'b000);
      for (int k = 0; k < 3; k++) begin
        lanes[k].neg <= neg8[k];
        lanes[k].ovf <= (top8[k] >= g8);
        lanes[k].rem <= top8[k];
        lanes[k].lo  <= {mag8[k][tbpt_pkg::LO_BITS-1:0], {tbpt_pkg::FRAC_BITS{1'b0}}};
        lanes[k].q   <= '0;
      end
    end
  end

endmodule

// ===== design/tbpt_div.sv =====
// ----------------------------------------------------------------------------
// Barycentric point test divider
// Three restoring division lanes sharing the Gram divisor, one quotient bit
// per stage, then rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module tbpt_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  tbpt_pkg::lane_t                        lanes [3],
  input  logic [tbpt_pkg::NUM_W-1:0]             gram_in,
  input  tbpt_pkg::flags_t                       flags,
  output logic                                   out_valid,
  output logic signed [tbpt_pkg::WEIGHT_BITS-1:0] weights [3],
  output logic                                   inside_res,
  output logic                                   degenerate
);

  localparam int NS = tbpt_pkg::WEIGHT_BITS;

  tbpt_pkg::lane_t            st_lane  [NS+1][3];
  logic [tbpt_pkg::NUM_W-1:0] st_gram  [NS+1];
  tbpt_pkg::flags_t           st_flags [NS+1];
  logic                       st_valid [NS+1];

  always_comb begin
    st_valid[0] = in_valid;
    st_gram[0]  = gram_in;
    st_flags[0] = flags;
    for (int k = 0; k < 3; k++) begin
      st_lane[0][k] = lanes[k];
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (en) begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_gram[s+1]  <= st_gram[s];
        st_flags[s+1] <= st_flags[s];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [tbpt_pkg::NUM_W:0] trial;
      logic                     fits;
      tbpt_pkg::lane_t          nxt;

      always_comb begin
        trial   = {st_lane[s][k].rem, st_lane[s][k].lo[NS-1]};
        fits    = trial >= {1'b0, st_gram[s]};
        nxt     = st_lane[s][k];
        nxt.rem = fits ? tbpt_pkg::NUM_W'(trial - {1'b0, st_gram[s]})
                       : tbpt_pkg::NUM_W'(trial);
        nxt.lo  = {st_lane[s][k].lo[NS-2:0], 1'b0};
        nxt.q   = {st_lane[s][k].q[NS-2:0], fits};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_lane[s+1][k] <= nxt;
        end
      end
    end
  end

  logic [NS:0]   qr  [3];
  logic [NS-1:0] res [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qr[k] = {1'b0, st_lane[NS][k].q}
            + (NS+1)'({st_lane[NS][k].rem, 1'b0} >= {1'b0, st_gram[NS]});
      if (st_flags[NS].degen) begin
        res[k] = '0;
      end else if (st_lane[NS][k].neg) begin
        if (st_lane[NS][k].ovf || qr[k] > {1'b0, tbpt_pkg::W_NEG_MAG}) begin
          res[k] = tbpt_pkg::W_NEG_MAG;
        end else begin
          res[k] = {NS{1'b0}} - qr[k][NS-1:0];
        end
      end else begin
        if (st_lane[NS][k].ovf || qr[k] > {1'b0, tbpt_pkg::W_POS_MAX}) begin
          res[k] = tbpt_pkg::W_POS_MAX;
        end else begin
          res[k] = qr[k][NS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        weights[k] <= $signed(res[k]);
      end
      inside_res <= st_flags[NS].in_tri;
      degenerate <= st_flags[NS].degen;
    end
  end

endmodule

// ===== design/triangle_barycentric_point_test.sv =====
// ----------------------------------------------------------------------------
// Barycentric point-in-triangle test
// Barycentric weights of a point against a 3-D triangle, with an exact inside
// flag and a degenerate flag, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   input    in_valid, in_stall   vertex_a/b/c_x/y/z, point_x/y/z
//   output   out_valid, out_stall weight_a/b/c, inside_res, degenerate
//
// An item passes from acceptance to its result through three stages of dot
// products, six of wide products and numerators, 24 quotient-bit stages and
// one rounding stage that holds the output register. One item may enter in
// every cycle. A stalled result holds the whole pipeline, so in_stall follows
// out_stall while the output register is full. Reset clears all valid bits.
// ----------------------------------------------------------------------------
`include "triangle_barycentric_point_test_assert.svh"

module triangle_barycentric_point_test (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_a_x,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_a_y,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_a_z,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_b_x,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_b_y,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_b_z,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_c_x,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_c_y,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  vertex_c_z,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [tbpt_pkg::COORD_BITS-1:0]  point_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tbpt_pkg::WEIGHT_BITS-1:0] weight_a,
  output logic signed [tbpt_pkg::WEIGHT_BITS-1:0] weight_b,
  output logic signed [tbpt_pkg::WEIGHT_BITS-1:0] weight_c,
  output logic                                    inside_res,
  output logic                                    degenerate
);

  logic                                    en;
  logic signed [tbpt_pkg::COORD_BITS-1:0]  coord [tbpt_pkg::NUM_COORDS];
  logic                                    front_valid;
  tbpt_pkg::dots_t                         dots;
  logic                                    gram_valid;
  tbpt_pkg::lane_t                         lanes [3];
  logic [tbpt_pkg::NUM_W-1:0]              gram;
  tbpt_pkg::flags_t                        flags;
  logic signed [tbpt_pkg::WEIGHT_BITS-1:0] weights [3];
  logic                                    weights_zero;
  logic                                    weights_nonneg;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign coord[0]  = vertex_a_x;
  assign coord[1]  = vertex_a_y;
  assign coord[2]  = vertex_a_z;
  assign coord[3]  = vertex_b_x;
  assign coord[4]  = vertex_b_y;
  assign coord[5]  = vertex_b_z;
  assign coord[6]  = vertex_c_x;
  assign coord[7]  = vertex_c_y;
  assign coord[8]  = vertex_c_z;
  assign coord[9]  = point_x;
  assign coord[10] = point_y;
  assign coord[11] = point_z;

  tbpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .coord     (coord),
    .out_valid (front_valid),
    .dots      (dots)
  );

  tbpt_gram u_gram (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .dots      (dots),
    .out_valid (gram_valid),
    .lanes     (lanes),
    .gram_out  (gram),
    .flags     (flags)
  );

  tbpt_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (gram_valid),
    .lanes      (lanes),
    .gram_in    (gram),
    .flags      (flags),
    .out_valid  (out_valid),
    .weights    (weights),
    .inside_res (inside_res),
    .degenerate (degenerate)
  );

  assign weight_a = weights[0];
  assign weight_b = weights[1];
  assign weight_c = weights[2];

  assign weights_zero   = (weight_a == '0) && (weight_b == '0) && (weight_c == '0);
  assign weights_nonneg = !weight_a[tbpt_pkg::WEIGHT_BITS-1]
                       && !weight_b[tbpt_pkg::WEIGHT_BITS-1]
                       && !weight_c[tbpt_pkg::WEIGHT_BITS-1];

  // A degenerate triangle gives zero weights and is never inside.
  `TBPT_ASSERT_NOW(a_degen_zero, out_valid && degenerate, weights_zero && !inside_res)
  // An inside point never shows a negative weight.
  `TBPT_ASSERT_NOW(a_inside_sign, out_valid && inside_res, weights_nonneg)
  // A stalled result keeps the pipeline frozen, so the next cycle shows it again.
  `TBPT_ASSERT_NEXT(a_stall_freeze, out_valid && out_stall, out_valid && $stable(weight_a))

endmodule
